[src/uvs_pkg.sv]
// ----------------------------------------------------------------------------
// UV sphere package
// Shared constants, the arctangent table and the controller-datapath types.
// ----------------------------------------------------------------------------
package uvs_pkg;

  localparam int MAX_SECTORS  = 64;
  localparam int MAX_STACKS   = 64;
  localparam int FRAC_BITS    = 14;
  localparam int CORDIC_STEPS = 24;
  localparam int STEP_W       = 5;
  localparam int DIV_W        = 7;

  localparam logic [1:0] KIND_VERTEX   = 2'd0;
  localparam logic [1:0] KIND_TRIANGLE = 2'd1;
  localparam logic [1:0] KIND_DONE     = 2'd2;

  localparam logic [0:0] CFG_SECTORS = 1'b0;
  localparam logic [0:0] CFG_STACKS  = 1'b1;

  localparam logic [33:0] HALF_PI_Q30 = 34'd1686629713;
  localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

  typedef struct packed {
    logic       start;
    logic [6:0] row;
    logic [6:0] col;
    logic [6:0] s_cnt;
    logic [6:0] t_cnt;
  } uvs_cmd_t;

  typedef struct packed {
    logic done;
  } uvs_sts_t;

  function automatic logic signed [33:0] atan_q30(input logic [STEP_W-1:0] k);
    logic signed [33:0] v;
    case (k)
      5'd0:  v = 34'sh3243F6A8;
      5'd1:  v = 34'sh1DAC6705;
      5'd2:  v = 34'sh0FADBAFC;
      5'd3:  v = 34'sh07F56EA6;
      5'd4:  v = 34'sh03FEAB76;
      5'd5:  v = 34'sh01FFD55B;
      5'd6:  v = 34'sh00FFFAAA;
      5'd7:  v = 34'sh007FFF55;
      5'd8:  v = 34'sh003FFFEA;
      5'd9:  v = 34'sh001FFFFD;
      5'd10: v = 34'sh000FFFFF;
      5'd11: v = 34'sh0007FFFF;
      5'd12: v = 34'sh0003FFFF;
      5'd13: v = 34'sh0001FFFF;
      5'd14: v = 34'sh0000FFFF;
      5'd15: v = 34'sh00007FFF;
      5'd16: v = 34'sh00003FFF;
      5'd17: v = 34'sh00001FFF;
      5'd18: v = 34'sh00000FFF;
      5'd19: v = 34'sh000007FF;
      5'd20: v = 34'sh000003FF;
      5'd21: v = 34'sh000001FF;
      5'd22: v = 34'sh000000FF;
      5'd23: v = 34'sh0000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[src/uvs_if.sv]
// ----------------------------------------------------------------------------
// UV sphere channels
// Valid/ready interfaces for the tick input and the mesh element output.
// ----------------------------------------------------------------------------
interface uvs_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface uvs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic [16:0]        tex_s;
  logic [16:0]        tex_t;
  logic [12:0]        index_a;
  logic [12:0]        index_b;
  logic [12:0]        index_c;
  logic               last;
  modport source (output valid, output kind, output pos_x, output pos_y, output pos_z,
                  output tex_s, output tex_t, output index_a, output index_b,
                  output index_c, output last, input ready);
  modport sink   (input valid, input kind, input pos_x, input pos_y, input pos_z,
                  input tex_s, input tex_t, input index_a, input index_b,
                  input index_c, input last, output ready);
endinterface

[src/uvs_datapath.sv]
// ----------------------------------------------------------------------------
// UV sphere vertex datapath
// Phase dividers, two shared-step CORDIC rotators and the position products.
// ----------------------------------------------------------------------------
module uvs_datapath
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  uvs_cmd_t           cmd,
  output uvs_sts_t           sts,
  output logic signed [15:0] pos_x,
  output logic signed [15:0] pos_y,
  output logic signed [15:0] pos_z,
  output logic [16:0]        tex_s,
  output logic [16:0]        tex_t
);

  typedef enum logic [2:0] {
    DP_IDLE, DP_DIV, DP_ANGLE, DP_ROT, DP_QUAD, DP_MUL, DP_PACK
  } dp_state_t;

  dp_state_t state_r;
  logic [5:0] cnt_r;
  // Restoring division of i*2^31/T and j*2^32/S, one quotient bit a cycle.
  logic [39:0] num_u_r, num_v_r;
  logic [6:0]  rem_u_r, rem_v_r;
  logic [6:0]  s_r, t_r;
  logic [1:0]  q_u_r, q_v_r;
  logic signed [33:0] x_u_r, y_u_r, z_u_r, x_v_r, y_v_r, z_v_r;
  logic signed [33:0] cu_r, su_r, cv_r, sv_r;
  logic signed [67:0] px_r, py_r;

  logic [7:0] tu, tv;
  logic [31:0] ph_u_w;
  logic [4:0] k;
  logic signed [33:0] at;

  assign k  = cnt_r[4:0];
  assign at = atan_q30(k);
  assign tu = {rem_u_r, num_u_r[39]};
  assign tv = {rem_v_r, num_v_r[39]};
  assign sts.done = (state_r == DP_IDLE);

  // The scaled angle reaches about 1.57 in Q2.30, so it needs 31 bits.
  function automatic logic signed [33:0] to_rad(input logic [29:0] r);
    logic [63:0] p;
    p = {34'd0, r} * {30'd0, HALF_PI_Q30};
    return $signed({3'd0, p[60:30]});
  endfunction

  function automatic logic signed [15:0] pack(input logic signed [67:0] v,
                                              input int unsigned sh);
    logic signed [67:0] r;
    logic signed [67:0] lim;
    r = (v + (68'sd1 <<< (sh - 1))) >>> sh;
    lim = 68'sd1 <<< FRAC_BITS;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r[15:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= DP_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        DP_IDLE: begin
          if (cmd.start) begin
            s_r <= cmd.s_cnt;
            t_r <= cmd.t_cnt;
            num_u_r <= {2'b00, cmd.row, 31'd0};
            num_v_r <= {1'b0, cmd.col, 32'd0};
            rem_u_r <= '0;
            rem_v_r <= '0;
            cnt_r <= '0;
            tex_s <= '0;
            tex_t <= '0;
            state_r <= DP_DIV;
          end
        end
        DP_DIV: begin
          num_u_r <= {num_u_r[38:0], (tu >= {1'b0, t_r})};
          num_v_r <= {num_v_r[38:0], (tv >= {1'b0, s_r})};
          rem_u_r <= (tu >= {1'b0, t_r}) ? 7'(tu - {1'b0, t_r}) : tu[6:0];
          rem_v_r <= (tv >= {1'b0, s_r}) ? 7'(tv - {1'b0, s_r}) : tv[6:0];
          if (cnt_r == 6'd39) state_r <= DP_ANGLE;
          cnt_r <= cnt_r + 6'd1;
        end
        DP_ANGLE: begin
          // The sector quotient has 2^32 scale and the stack quotient 2^31, so
          // the 2^16 texture values sit 16 and 15 bits up.
          tex_s <= num_v_r[32:16];
          tex_t <= num_u_r[31:15];
          q_u_r <= ph_u_w[31:30];
          q_v_r <= num_v_r[31:30];
          z_u_r <= to_rad(ph_u_w[29:0]);
          z_v_r <= to_rad(num_v_r[29:0]);
          x_u_r <= CORDIC_X0; y_u_r <= '0;
          x_v_r <= CORDIC_X0; y_v_r <= '0;
          cnt_r <= '0;
          state_r <= DP_ROT;
        end
        DP_ROT: begin
          if (z_u_r >= 0) begin
            x_u_r <= x_u_r - (y_u_r >>> k); y_u_r <= y_u_r + (x_u_r >>> k);
            z_u_r <= z_u_r - at;
          end else begin
            x_u_r <= x_u_r + (y_u_r >>> k); y_u_r <= y_u_r - (x_u_r >>> k);
            z_u_r <= z_u_r + at;
          end
          if (z_v_r >= 0) begin
            x_v_r <= x_v_r - (y_v_r >>> k); y_v_r <= y_v_r + (x_v_r >>> k);
            z_v_r <= z_v_r - at;
          end else begin
            x_v_r <= x_v_r + (y_v_r >>> k); y_v_r <= y_v_r - (x_v_r >>> k);
            z_v_r <= z_v_r + at;
          end
          if (cnt_r == 6'(CORDIC_STEPS - 1)) state_r <= DP_QUAD;
          cnt_r <= cnt_r + 6'd1;
        end
        DP_QUAD: begin
          case (q_u_r)
            2'd0: begin cu_r <= x_u_r;  su_r <= y_u_r;  end
            2'd1: begin cu_r <= -y_u_r; su_r <= x_u_r;  end
            2'd2: begin cu_r <= -x_u_r; su_r <= -y_u_r; end
            default: begin cu_r <= y_u_r; su_r <= -x_u_r; end
          endcase
          case (q_v_r)
            2'd0: begin cv_r <= x_v_r;  sv_r <= y_v_r;  end
            2'd1: begin cv_r <= -y_v_r; sv_r <= x_v_r;  end
            2'd2: begin cv_r <= -x_v_r; sv_r <= -y_v_r; end
            default: begin cv_r <= y_v_r; sv_r <= -x_v_r; end
          endcase
          state_r <= DP_MUL;
        end
        DP_MUL: begin
          px_r <= 68'(cu_r) * 68'(cv_r);
          py_r <= 68'(cu_r) * 68'(sv_r);
          state_r <= DP_PACK;
        end
        DP_PACK: begin
          pos_x <= pack(px_r, 60 - FRAC_BITS);
          pos_y <= pack(py_r, 60 - FRAC_BITS);
          pos_z <= pack(68'(su_r), 30 - FRAC_BITS);
          state_r <= DP_IDLE;
        end
        default: state_r <= DP_IDLE;
      endcase
    end
  end

  // Stack phase: quarter turn minus floor(i*2^31/T), held in the low quotient bits.
  assign ph_u_w = 32'h4000_0000 - num_u_r[31:0];

endmodule

[src/uvs_controller.sv]
// ----------------------------------------------------------------------------
// UV sphere controller
// Mesh walk counters, triangle indexing and the output register.
// ----------------------------------------------------------------------------
module uvs_controller
  import uvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic [6:0]         sector_count,
  input  logic [6:0]         stack_count,
  uvs_in_if.sink             in_ch,
  uvs_out_if.source          out_ch,
  output uvs_cmd_t           cmd,
  input  uvs_sts_t           sts,
  input  logic signed [15:0] dp_x,
  input  logic signed [15:0] dp_y,
  input  logic signed [15:0] dp_z,
  input  logic [16:0]        dp_s,
  input  logic [16:0]        dp_t
);

  typedef enum logic [1:0] {ST_IDLE, ST_LAUNCH, ST_WAIT, ST_OUT} st_t;
  typedef enum logic [1:0] {PH_VERTEX, PH_TRIANGLE, PH_DONE} ph_t;

  st_t  state_r;
  ph_t  phase_r;
  logic [6:0]  row_r, col_r;
  logic        sec_r;
  logic [12:0] base_r;
  logic [6:0]  s_cl, t_cl;

  assign s_cl = (sector_count < 7'd3) ? 7'd3 :
                (sector_count > 7'(MAX_SECTORS)) ? 7'(MAX_SECTORS) : sector_count;
  assign t_cl = (stack_count < 7'd2) ? 7'd2 :
                (stack_count > 7'(MAX_STACKS)) ? 7'(MAX_STACKS) : stack_count;

  assign in_ch.ready = (state_r == ST_IDLE);

  // Combinational evaluation of one tick in triangle or done phase.
  ph_t  ph0;
  logic [6:0]  r0, c0, r1, c1, r2, c2;
  logic        s0, s1, s2, fin, emit;
  logic [12:0] b0, b1, b2, k1, k2;

  // Walk state and result fields that an accepted tick leaves behind.
  ph_t         phase_nxt;
  logic [6:0]  row_nxt, col_nxt;
  logic        sec_nxt;
  logic [12:0] base_nxt;
  logic [1:0]  kind_nxt;
  logic [12:0] index_a_nxt, index_b_nxt, index_c_nxt;
  logic        last_nxt;

  function automatic logic tri_ok(input logic [6:0] i, input logic sc, input logic [6:0] t);
    return sc ? (i != 7'(t - 7'd1)) : (i != 7'd0);
  endfunction

  always_comb begin
    r0 = in_ch.restart ? 7'd0 : row_r;
    c0 = in_ch.restart ? 7'd0 : col_r;
    s0 = in_ch.restart ? 1'b0 : sec_r;
    b0 = in_ch.restart ? 13'd0 : base_r;
    ph0 = in_ch.restart ? PH_VERTEX : phase_r;
    // Up to two skipped triangles.
    r1 = r0; c1 = c0; s1 = s0; b1 = b0;
    if (r0 < t_cl && !tri_ok(r0, s0, t_cl)) begin
      if (!s0) s1 = 1'b1;
      else begin
        s1 = 1'b0;
        if (c0 + 7'd1 >= s_cl) begin c1 = '0; r1 = r0 + 7'd1; b1 = b0 + 13'(s_cl) + 13'd1; end
        else c1 = c0 + 7'd1;
      end
    end
    r2 = r1; c2 = c1; s2 = s1; b2 = b1;
    if (r1 < t_cl && !tri_ok(r1, s1, t_cl)) begin
      if (!s1) s2 = 1'b1;
      else begin
        s2 = 1'b0;
        if (c1 + 7'd1 >= s_cl) begin c2 = '0; r2 = r1 + 7'd1; b2 = b1 + 13'(s_cl) + 13'd1; end
        else c2 = c1 + 7'd1;
      end
    end
    emit = (r2 < t_cl);
    k1 = b2 + 13'(c2);
    k2 = k1 + 13'(s_cl) + 13'd1;
    fin = (r2 == 7'(t_cl - 7'd1)) && (c2 >= 7'(s_cl - 7'd1)) && !s2;
  end

  // Next walk position and the result fields for the tick on the input.
  always_comb begin
    phase_nxt   = PH_DONE;
    row_nxt     = r2;
    col_nxt     = c2;
    sec_nxt     = s2;
    base_nxt    = b2;
    kind_nxt    = KIND_DONE;
    index_a_nxt = '0;
    index_b_nxt = '0;
    index_c_nxt = '0;
    last_nxt    = 1'b0;
    if (ph0 == PH_VERTEX) begin
      kind_nxt  = KIND_VERTEX;
      phase_nxt = PH_VERTEX;
      sec_nxt   = s0;
      base_nxt  = b0;
      if (c0 >= s_cl) begin
        col_nxt = '0;
        if (r0 >= t_cl) begin
          phase_nxt = PH_TRIANGLE;
          row_nxt   = '0;
          sec_nxt   = 1'b0;
          base_nxt  = '0;
        end else begin
          row_nxt = r0 + 7'd1;
        end
      end else begin
        col_nxt = c0 + 7'd1;
        row_nxt = r0;
      end
    end else if (ph0 == PH_TRIANGLE && emit) begin
      kind_nxt    = KIND_TRIANGLE;
      index_a_nxt = s2 ? k1 + 13'd1 : k1;
      index_b_nxt = k2;
      index_c_nxt = s2 ? k2 + 13'd1 : k1 + 13'd1;
      last_nxt    = fin;
      phase_nxt   = fin ? PH_DONE : PH_TRIANGLE;
      if (!fin) begin
        if (!s2) begin
          sec_nxt = 1'b1;
        end else begin
          sec_nxt = 1'b0;
          if (c2 + 7'd1 >= s_cl) begin
            col_nxt  = '0;
            row_nxt  = r2 + 7'd1;
            base_nxt = b2 + 13'(s_cl) + 13'd1;
          end else begin
            col_nxt = c2 + 7'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_VERTEX;
      row_r <= '0; col_r <= '0; sec_r <= 1'b0; base_r <= '0;
      out_ch.valid <= 1'b0;
      cmd.start <= 1'b0;
    end else begin
      cmd.start <= (state_r == ST_IDLE) && in_ch.valid && (ph0 == PH_VERTEX);
      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            row_r <= row_nxt; col_r <= col_nxt; sec_r <= sec_nxt; base_r <= base_nxt;
            phase_r <= phase_nxt;
            out_ch.kind <= kind_nxt;
            out_ch.pos_x <= '0; out_ch.pos_y <= '0; out_ch.pos_z <= '0;
            out_ch.tex_s <= '0; out_ch.tex_t <= '0;
            out_ch.index_a <= index_a_nxt;
            out_ch.index_b <= index_b_nxt;
            out_ch.index_c <= index_c_nxt;
            out_ch.last <= last_nxt;
            if (ph0 == PH_VERTEX) begin
              cmd.row <= r0; cmd.col <= c0; cmd.s_cnt <= s_cl; cmd.t_cnt <= t_cl;
              state_r <= ST_LAUNCH;
            end else begin
              out_ch.valid <= 1'b1;
              state_r <= ST_OUT;
            end
          end
        end
        ST_LAUNCH: state_r <= ST_WAIT;
        ST_WAIT: begin
          if (sts.done) begin
            out_ch.pos_x <= dp_x; out_ch.pos_y <= dp_y; out_ch.pos_z <= dp_z;
            out_ch.tex_s <= dp_s; out_ch.tex_t <= dp_t;
            out_ch.valid <= 1'b1;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_ch.valid <= 1'b0;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[src/uv_sphere_mesh_generator_unit.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator
// Emits the vertices and then the triangles of a unit UV sphere, one per tick.
// ----------------------------------------------------------------------------
// Usage: every item on the input channel is a tick; restart=1 rewinds to the
// first vertex and that tick already yields it. Each tick yields exactly one
// item on the output channel: a vertex, a triangle or a done marker.
// Vertex ticks go from acceptance to a valid result through datapath launch,
// a restoring divider for the two angle phases, angle setup, 24 shared CORDIC
// rotation steps, then one quadrant stage, one multiply stage, one rounding
// stage and the capture. Triangle and done ticks answer in the cycle after
// acceptance. One tick is in flight at a time; the next is accepted once the
// result has been taken, so a stalled receiver simply holds the result and
// the input. Reset sets both counts to 10 and rewinds the mesh walk. The
// configuration port writes sector_count (index 0) or stack_count (index 1);
// the user must write only while idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator_unit
  import uvs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [6:0] cfg_data,
  uvs_in_if.sink     in_ch,
  uvs_out_if.source  out_ch
);

  logic [6:0] sector_count_r, stack_count_r;
  uvs_cmd_t cmd;
  uvs_sts_t sts;
  logic signed [15:0] dp_x, dp_y, dp_z;
  logic [16:0] dp_s, dp_t;

  // Configuration registers; counts are clamped where they are used.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sector_count_r <= 7'd10;
      stack_count_r  <= 7'd10;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SECTORS: sector_count_r <= cfg_data;
        CFG_STACKS:  stack_count_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  uvs_controller u_ctrl (
    .clk, .rst_n,
    .sector_count(sector_count_r), .stack_count(stack_count_r),
    .in_ch, .out_ch, .cmd, .sts,
    .dp_x, .dp_y, .dp_z, .dp_s, .dp_t
  );

  uvs_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .pos_x(dp_x), .pos_y(dp_y), .pos_z(dp_z), .tex_s(dp_s), .tex_t(dp_t)
  );

`ifndef SYNTH
  // A result is never offered while the block is ready for a new tick.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_ch.valid && in_ch.ready)) else $error("result and ready overlap");
  // An accepted tick blocks further acceptance on the next cycle.
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready) else $error("second tick taken");
  // The datapath is busy right after a start command.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |=> !sts.done) else $error("datapath did not start");
`endif

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// UV sphere mesh generator testbench
// Feeds restart and advance ticks through the input channel and checks every
// vertex, triangle and done item against a bit-accurate mesh walker that runs
// CORDIC sine and cosine in fixed point. Configuration changes between phases
// and uses extreme and out-of-range counts. Both channels idle at random.
// ----------------------------------------------------------------------------
module tb_top
  import uvs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int NUM_PHASES     = 12;
  localparam int TICKS_PER_PHASE = 105;

  // The walker's position in the mesh.
  typedef enum logic [1:0] {
    WALK_VERTEX   = 2'd0,
    WALK_TRIANGLE = 2'd1,
    WALK_DONE     = 2'd2
  } walk_t;

  // One mesh item as the block should emit it.
  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [16:0]        tex_s;
    logic [16:0]        tex_t;
    logic [12:0]        index_a;
    logic [12:0]        index_b;
    logic [12:0]        index_c;
    logic               last;
  } mesh_elem_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [0:0] cfg_index;
  logic [6:0] cfg_data;

  uvs_in_if  in_ch ();
  uvs_out_if out_ch ();

  uv_sphere_mesh_generator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // Arctangent of 2^-k in Q2.30 radians, one entry per rotation step.
  localparam longint ATAN_STEP [24] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
  };

  // Walker copy of the configuration and of the block's state.
  logic [6:0]  sectors_reg;
  logic [6:0]  stacks_reg;
  int unsigned walk_row;
  int unsigned walk_col;
  walk_t       walk_phase;
  logic        walk_second;
  int unsigned walk_row_base;

  logic       ticks_pending [$];   // restart bits waiting to be sent
  mesh_elem_t mesh_elems_due [$];  // items the block still owes

  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned mismatch_count;
  int unsigned idle_cycles;
  int unsigned vertex_count;
  int unsigned triangle_count;
  int unsigned done_count;
  int unsigned restart_count;

  // ---------------------------------------------------------------------------
  // Clock and reset. Reset is held low at the start and never again.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Fixed-point sine and cosine of a phase given as a 32-bit fraction of a
  // turn. The top two bits pick the quadrant; the rest is rotated by CORDIC.
  // ---------------------------------------------------------------------------
  function automatic void turn_sincos(input logic [31:0] ph, output longint c,
                                      output longint s);
    longint unsigned r;
    longint x, y, z, dx, dy;
    r = longint'(ph[29:0]);
    z = longint'((r * 64'd1686629713) >> 30);
    x = 652032874;
    y = 0;
    for (int k = 0; k < 24; k++) begin
      dx = y >>> k;
      dy = x >>> k;
      if (z >= 0) begin
        x = x - dx;
        y = y + dy;
        z = z - ATAN_STEP[k];
      end else begin
        x = x + dx;
        y = y - dy;
        z = z + ATAN_STEP[k];
      end
    end
    case (ph[31:30])
      2'd0: begin c = x;  s = y;  end
      2'd1: begin c = -y; s = x;  end
      2'd2: begin c = -x; s = -y; end
      default: begin c = y;  s = -x; end
    endcase
  endfunction

  // Round half up by a right shift, then saturate to +-1.0 in Q2.14.
  function automatic logic [15:0] to_q2_14(input longint v, input int sh);
    longint lim;
    longint t;
    lim = longint'(1) << FRAC_BITS;
    t = (v + (longint'(1) << (sh - 1))) >>> sh;
    if (t > lim) t = lim;
    if (t < -lim) t = -lim;
    return t[15:0];
  endfunction

  function automatic int unsigned clamp_count(input logic [6:0] v, input int unsigned lo,
                                              input int unsigned hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Moves to the next triangle slot: second half of a quad, or next quad.
  function automatic void next_triangle(input int unsigned sec_n);
    if (!walk_second) begin
      walk_second = 1'b1;
    end else begin
      walk_second = 1'b0;
      if (walk_col + 1 >= sec_n) begin
        walk_col = 0;
        walk_row = walk_row + 1;
        walk_row_base = walk_row_base + sec_n + 1;
      end else begin
        walk_col = walk_col + 1;
      end
    end
  endfunction

  // Advances the mesh walk by one tick and returns the item it yields.
  function automatic mesh_elem_t advance_mesh(input logic restart);
    mesh_elem_t  e;
    int unsigned sec_n, stk_n, i, j, k1, k2;
    logic [31:0] ph_u, ph_v;
    longint      cu, su, cv, sv;
    logic        fin;
    logic        skip;
    e = '0;
    sec_n = clamp_count(sectors_reg, 3, MAX_SECTORS);
    stk_n = clamp_count(stacks_reg, 2, MAX_STACKS);
    if (restart) begin
      walk_row = 0;
      walk_col = 0;
      walk_phase = WALK_VERTEX;
      walk_second = 1'b0;
      walk_row_base = 0;
    end

    if (walk_phase == WALK_VERTEX) begin
      i = walk_row;
      j = walk_col;
      ph_u = 32'(64'h40000000 - ((longint'(i) << 31) / stk_n));
      ph_v = 32'((longint'(j) << 32) / sec_n);
      turn_sincos(ph_u, cu, su);
      turn_sincos(ph_v, cv, sv);
      e.kind  = KIND_VERTEX;
      e.pos_x = to_q2_14(cu * cv, 60 - FRAC_BITS);
      e.pos_y = to_q2_14(cu * sv, 60 - FRAC_BITS);
      e.pos_z = to_q2_14(su, 30 - FRAC_BITS);
      e.tex_s = 17'((longint'(j) << 16) / sec_n);
      e.tex_t = 17'((longint'(i) << 16) / stk_n);
      // A column at or past the sector count closes the row; a closed row at
      // or past the stack count hands over to the triangle walk.
      if (j >= sec_n) begin
        walk_col = 0;
        if (i >= stk_n) begin
          walk_phase = WALK_TRIANGLE;
          walk_row = 0;
          walk_second = 1'b0;
          walk_row_base = 0;
        end else begin
          walk_row = i + 1;
        end
      end else begin
        walk_col = j + 1;
      end
      return e;
    end

    if (walk_phase == WALK_TRIANGLE) begin
      // The polar rows have one triangle per quad: skip the missing one.
      for (int n = 0; n < 2; n++) begin
        skip = walk_second ? (walk_row == stk_n - 1) : (walk_row == 0);
        if (walk_row < stk_n && skip) next_triangle(sec_n);
      end
      if (walk_row >= stk_n) begin
        walk_phase = WALK_DONE;
      end else begin
        k1 = walk_row_base + walk_col;
        k2 = k1 + sec_n + 1;
        fin = (walk_row == stk_n - 1) && (walk_col >= sec_n - 1) && !walk_second;
        e.kind = KIND_TRIANGLE;
        if (!walk_second) begin
          e.index_a = 13'(k1);
          e.index_b = 13'(k2);
          e.index_c = 13'(k1 + 1);
        end else begin
          e.index_a = 13'(k1 + 1);
          e.index_b = 13'(k2);
          e.index_c = 13'(k2 + 1);
        end
        e.last = fin;
        if (fin) walk_phase = WALK_DONE;
        else next_triangle(sec_n);
        return e;
      end
    end

    e.kind = KIND_DONE;
    return e;
  endfunction

  task automatic flag_mismatch(input string field, input longint got, input longint want);
    $display("[%0t] MISMATCH %s: got %0d, expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver. A tick stays on the channel until it is taken; only then may the
  // sender go idle. The walker advances at the edge that accepts the tick.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid   <= 1'b0;
      in_ch.restart <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        mesh_elems_due = {mesh_elems_due, advance_mesh(in_ch.restart)};
        if (in_ch.restart) restart_count++;
        void'(ticks_pending.pop_front());
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (ticks_pending.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_ch.valid   <= 1'b1;
          in_ch.restart <= ticks_pending[0];
        end else begin
          in_ch.valid   <= 1'b0;
          in_ch.restart <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Each item taken from the block is checked field by field against
  // the oldest outstanding prediction.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    mesh_elem_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (mesh_elems_due.size() == 0) begin
          flag_mismatch("kind of an item with no prediction pending", out_ch.kind, -1);
        end else begin
          want = mesh_elems_due.pop_front();
          case (want.kind)
            KIND_VERTEX: vertex_count++;
            KIND_TRIANGLE: triangle_count++;
            default: done_count++;
          endcase
          if (out_ch.kind !== want.kind) flag_mismatch("kind", out_ch.kind, want.kind);
          if (out_ch.pos_x !== want.pos_x) flag_mismatch("pos_x", out_ch.pos_x, want.pos_x);
          if (out_ch.pos_y !== want.pos_y) flag_mismatch("pos_y", out_ch.pos_y, want.pos_y);
          if (out_ch.pos_z !== want.pos_z) flag_mismatch("pos_z", out_ch.pos_z, want.pos_z);
          if (out_ch.tex_s !== want.tex_s) flag_mismatch("tex_s", out_ch.tex_s, want.tex_s);
          if (out_ch.tex_t !== want.tex_t) flag_mismatch("tex_t", out_ch.tex_t, want.tex_t);
          if (out_ch.index_a !== want.index_a)
            flag_mismatch("index_a", out_ch.index_a, want.index_a);
          if (out_ch.index_b !== want.index_b)
            flag_mismatch("index_b", out_ch.index_b, want.index_b);
          if (out_ch.index_c !== want.index_c)
            flag_mismatch("index_c", out_ch.index_c, want.index_c);
          if (out_ch.last !== want.last) flag_mismatch("last", out_ch.last, want.last);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog. Any acceptance on either channel resets the count; a long run
  // of silent cycles means the block has hung.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout after %0d cycles without progress", WATCHDOG_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Register write, driven at the rising edge and held for one cycle. The
  // walker copy is updated when the write is driven, before the block samples it.
  task automatic write_count(input logic [0:0] idx, input logic [6:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == CFG_SECTORS) sectors_reg = val;
    else stacks_reg = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every tick is sent and every item has come back, then lets the
  // block settle for longer than a vertex takes.
  task automatic wait_idle();
    @(negedge clk);
    while (ticks_pending.size() > 0 || mesh_elems_due.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. A directed walk over the smallest sphere comes first, then
  // phases with new counts and a new idling pattern each. Counts change
  // without a restart, so the walk often sits beyond the new bounds.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    logic [6:0]  sec_val, stk_val;
    cfg_we = 1'b0;
    cfg_index = CFG_SECTORS;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    sectors_reg = 7'd10;
    stacks_reg = 7'd10;
    walk_row = 0;
    walk_col = 0;
    walk_phase = WALK_VERTEX;
    walk_second = 1'b0;
    walk_row_base = 0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    mismatch_count = 0;
    idle_cycles = 0;
    vertex_count = 0;
    triangle_count = 0;
    done_count = 0;
    restart_count = 0;

    wait (rst_n === 1'b1);
    // A few ticks at the reset counts before any write.
    @(negedge clk);
    repeat (3) ticks_pending = {ticks_pending, 1'b0};
    wait_idle();

    // Smallest sphere: restart, walk all 12 vertices and 6 triangles, a
    // couple of done ticks, then a restart out of the done state.
    write_count(CFG_SECTORS, 7'd3);
    write_count(CFG_STACKS, 7'd2);
    @(negedge clk);
    ticks_pending = {ticks_pending, 1'b1};
    repeat (19) ticks_pending = {ticks_pending, 1'b0};
    ticks_pending = {ticks_pending, 1'b1};
    ticks_pending = {ticks_pending, 1'b0};
    wait_idle();

    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: begin sec_val = 7'd0;   stk_val = 7'd0;   end   // below range
        1: begin sec_val = 7'd127; stk_val = 7'd127; end   // above range
        2: begin sec_val = 7'd64;  stk_val = 7'd2;   end
        3: begin sec_val = 7'd3;   stk_val = 7'd64;  end
        default: begin
          sec_val = 7'($urandom_range(6, 3));
          stk_val = 7'($urandom_range(5, 2));
        end
      endcase
      write_count(CFG_SECTORS, sec_val);
      write_count(CFG_STACKS, stk_val);
      mode = p % 4;
      sender_idle_pct    = (mode == 1) ? 74 : ((mode == 3) ? 32 : 0);
      receiver_stall_pct = (mode == 2) ? 74 : ((mode == 3) ? 32 : 0);
      @(negedge clk);
      // Mostly plain advances so the walk gets through whole meshes; an
      // occasional restart breaks a mesh off part way.
      for (int n = 0; n < TICKS_PER_PHASE; n++)
        ticks_pending = {ticks_pending, ($urandom_range(49) == 0)};
      wait_idle();
    end

    $display("Checked %0d vertices, %0d triangles and %0d done items (%0d restarts)",
             vertex_count, triangle_count, done_count, restart_count);
    $display("over %0d count settings with four idling patterns", NUM_PHASES + 2);
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
